/* rtl/core/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, round constants and round functions of the sha-256 engine
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned ROUNDS       = 64;
    localparam int unsigned BLOCK_WORDS  = 16;
    localparam int unsigned DIGEST_WORDS = 8;

    // one message word after classification by the front end
    typedef struct packed {
        t_word word;
        logic  reload;   // first word of a first block: restart from the initial hash
        logic  run;      // sixteenth word: block is complete, compress it
        logic  emit;     // sixteenth word of a last block: emit digest afterwards
    } t_item;

    localparam t_word K_TABLE [0:ROUNDS-1] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word IV_TABLE [0:DIGEST_WORDS-1] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

/* rtl/core/sha_front.sv */
// ----------------------------------------------------------------------------
// sha_front
// takes message words, tags block boundaries and flags, queues them for the core
// ----------------------------------------------------------------------------
module sha_front
    import sha_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_full,
    input  t_word i_message_word,
    input  logic  i_first_block,
    input  logic  i_last_block,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
    localparam logic [3:0]       LAST_WORD = 4'(BLOCK_WORDS - 1);

    t_item            r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [3:0]       r_pos;

    logic  push_ok;
    logic  take_ok;
    t_item n_item;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_queue[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign take_ok = i_take && o_valid;

    // flags only count on the block's first and sixteenth word
    always_comb begin
        n_item.word   = i_message_word;
        n_item.reload = (r_pos == '0) && i_first_block;
        n_item.run    = (r_pos == LAST_WORD);
        n_item.emit   = (r_pos == LAST_WORD) && i_last_block;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_pos    <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
                r_pos    <= r_pos + 1'b1;
            end
            if (take_ok) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !take_ok) begin
                r_count <= r_count + 1'b1;
            end else if (take_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_queue[r_wr_ptr] <= n_item;
        end
    end

endmodule

/* rtl/core/sha_back.sv */
// ----------------------------------------------------------------------------
// sha_back
// schedule window, round engine, hash update and digest readout
// ----------------------------------------------------------------------------
module sha_back
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_take,
    output logic       o_empty,
    input  logic       i_pop,
    output t_word      o_digest_word,
    output logic [2:0] o_digest_index,
    output logic       o_digest_last
);

    localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);
    localparam logic [2:0] LAST_INDEX = 3'(DIGEST_WORDS - 1);

    typedef enum logic [1:0] {
        S_LOAD,
        S_ROUND,
        S_FINAL,
        S_DIGEST
    } t_state;

    t_state     r_state;
    t_word      r_hash   [DIGEST_WORDS];
    t_word      r_var    [DIGEST_WORDS];
    t_word      r_window [BLOCK_WORDS];
    logic [5:0] r_round;
    logic [2:0] r_index;
    logic       r_emit;

    t_word n_sched;
    t_word n_t1;
    t_word n_t2;

    assign o_take         = (r_state == S_LOAD) && i_valid;
    assign o_empty        = (r_state != S_DIGEST);
    assign o_digest_word  = r_hash[r_index];
    assign o_digest_index = r_index;
    assign o_digest_last  = (r_index == LAST_INDEX);

    // window holds w[r..r+15]; the word sixteen ahead is built while round r runs
    always_comb begin
        n_sched = small_sigma1(r_window[14]) + r_window[9]
                + small_sigma0(r_window[1]) + r_window[0];
        n_t1 = r_var[7] + big_sigma1(r_var[4])
             + ((r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]))
             + K_TABLE[r_round] + r_window[0];
        n_t2 = big_sigma0(r_var[0])
             + ((r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_round <= '0;
            r_index <= '0;
            r_emit  <= 1'b0;
            for (int j = 0; j < DIGEST_WORDS; j++) begin
                r_hash[j] <= IV_TABLE[j];
                r_var[j]  <= '0;
            end
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (i_valid) begin
                        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                            r_window[i] <= r_window[i+1];
                        end
                        r_window[BLOCK_WORDS-1] <= i_item.word;
                        if (i_item.reload) begin
                            for (int j = 0; j < DIGEST_WORDS; j++) begin
                                r_hash[j] <= IV_TABLE[j];
                            end
                        end
                        if (i_item.run) begin
                            for (int j = 0; j < DIGEST_WORDS; j++) begin
                                r_var[j] <= r_hash[j];
                            end
                            r_emit  <= i_item.emit;
                            r_round <= '0;
                            r_state <= S_ROUND;
                        end
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                        r_window[i] <= r_window[i+1];
                    end
                    r_window[BLOCK_WORDS-1] <= n_sched;
                    r_var[7] <= r_var[6];
                    r_var[6] <= r_var[5];
                    r_var[5] <= r_var[4];
                    r_var[4] <= r_var[3] + n_t1;
                    r_var[3] <= r_var[2];
                    r_var[2] <= r_var[1];
                    r_var[1] <= r_var[0];
                    r_var[0] <= n_t1 + n_t2;
                    r_round  <= r_round + 1'b1;
                    if (r_round == LAST_ROUND) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    for (int j = 0; j < DIGEST_WORDS; j++) begin
                        r_hash[j] <= r_hash[j] + r_var[j];
                    end
                    r_index <= '0;
                    r_state <= r_emit ? S_DIGEST : S_LOAD;
                end
                S_DIGEST: begin
                    if (i_pop) begin
                        r_index <= r_index + 1'b1;
                        if (r_index == LAST_INDEX) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

/* rtl/core/sha256_block_compression_top.sv */
// ----------------------------------------------------------------------------
// sha256_block_compression_top
// sha-256 block compression engine with queue-style word input and digest output
// ----------------------------------------------------------------------------
// Takes a padded message as 32-bit big-endian words; every sixteen words form
// one block. first_block counts on a block's first word and restarts from the
// initial hash, last_block counts on its sixteenth word and makes the engine
// emit the eight digest words (index 0 first, last marker on index 7) once that
// block is compressed. A front queue of QUEUE_DEPTH words keeps taking input
// while the core is busy. The core takes one queued word per cycle while loading
// a block, then runs all rounds, one per cycle, adds the working variables into
// the hash, and takes no new word before that or, after a last block, before all
// eight digest words are popped. A single round unit does every round.
// ----------------------------------------------------------------------------
module sha256_block_compression_top
    import sha_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_message_word,
    input  logic        i_first_block,
    input  logic        i_last_block,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_digest_index,
    output logic        o_digest_last
);

    logic  item_valid;
    logic  item_take;
    t_item item;

    sha_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_message_word (i_message_word),
        .i_first_block  (i_first_block),
        .i_last_block   (i_last_block),
        .o_valid        (item_valid),
        .o_item         (item),
        .i_take         (item_take)
    );

    sha_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (item_valid),
        .i_item         (item),
        .o_take         (item_take),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_digest_word  (o_digest_word),
        .o_digest_index (o_digest_index),
        .o_digest_last  (o_digest_last)
    );

endmodule

/* bench/sha256_block_compression_top_tb.sv */
// ----------------------------------------------------------------------------
// sha256_block_compression_top_tb
// self-checking bench for the sha-256 block compression engine
// ----------------------------------------------------------------------------
// A queue of padded message words feeds a clocked driver that pushes in random
// bursts. Every accepted word goes through a local sha-256 predictor, which
// queues the eight expected digest words whenever a last block completes. A
// clocked monitor pops with its own stall pattern and compares each digest
// transfer against the oldest expected word.
// ----------------------------------------------------------------------------
module sha256_block_compression_top_tb;

    typedef struct {
        logic [31:0] word;
        logic        first;
        logic        last;
        logic        hold;   // wait until all digests are out before pushing
    } t_msg_word;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_entry;

    localparam logic [31:0] SHA_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] i_message_word = '0;
    logic        i_first_block = 1'b0;
    logic        i_last_block = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_digest_index;
    logic        o_digest_last;

    t_msg_word     pending_words[$];
    t_digest_entry digest_queue[$];

    logic [31:0] hash_state [0:7];
    logic [31:0] sched_window [0:15];
    logic [3:0]  word_pos = 4'd0;
    int          error_count = 0;

    int          burst_left = 8;
    int          gap_left = 0;
    int          recv_mode = 0;
    int          recv_left = 50;
    logic [7:0]  stall_mask = 8'hb5;
    logic [2:0]  stall_phase = 3'd0;

    sha256_block_compression_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_message_word (i_message_word),
        .i_first_block  (i_first_block),
        .i_last_block   (i_last_block),
        .empty          (empty),
        .pop            (pop),
        .o_digest_word  (o_digest_word),
        .o_digest_index (o_digest_index),
        .o_digest_last  (o_digest_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    // run the 64 rounds over the current window and fold into the hash state
    task automatic compress_window();
        logic [31:0] w [0:15];
        logic [31:0] v [0:7];
        logic [31:0] wr, x15, x2, s0, s1, ch, maj, t1, t2;
        for (int j = 0; j < 16; j++) w[j] = sched_window[j];
        for (int j = 0; j < 8; j++) v[j] = hash_state[j];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wr = w[r];
            end else begin
                x15 = w[(r - 15) & 15];
                x2  = w[(r - 2) & 15];
                s0 = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
                s1 = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);
                wr = w[r & 15] + s0 + w[(r - 7) & 15] + s1;
                w[r & 15] = wr;
            end
            s1  = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
            ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1  = v[7] + s1 + ch + SHA_K[r] + wr;
            s0  = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
            maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2  = s0 + maj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) hash_state[j] = hash_state[j] + v[j];
    endtask

    task automatic absorb_word(input t_msg_word item);
        t_digest_entry e;
        if (word_pos == 4'd0 && item.first) begin
            for (int j = 0; j < 8; j++) hash_state[j] = SHA_IV[j];
        end
        sched_window[word_pos] = item.word;
        if (word_pos == 4'd15) begin
            compress_window();
            if (item.last) begin
                for (int k = 0; k < 8; k++) begin
                    e.word  = hash_state[k];
                    e.index = 3'(k);
                    e.last  = (k == 7);
                    digest_queue.push_back(e);
                end
            end
        end
        word_pos = word_pos + 4'd1;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic add_word(input logic [31:0] word, input logic first, input logic last,
                            input logic hold);
        t_msg_word m;
        m.word  = word;
        m.first = first;
        m.last  = last;
        m.hold  = hold;
        pending_words.push_back(m);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // driver: bursts of pushes with random gaps between them
    always @(posedge i_clk) begin
        logic offer;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                absorb_word(pending_words.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(40, 120);
                        default: gap_left = $urandom_range(1, 10);
                    endcase
                end
            end
            offer = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_words.size() != 0) begin
                offer = !(pending_words[0].hold && digest_queue.size() != 0);
            end
            push <= offer;
            if (offer) begin
                i_message_word <= pending_words[0].word;
                i_first_block  <= pending_words[0].first;
                i_last_block   <= pending_words[0].last;
            end
        end
    end

    // monitor: stalls on its own pattern, checks every digest transfer
    always @(posedge i_clk) begin
        t_digest_entry e;
        logic pop_next;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (digest_queue.size() == 0) begin
                    report_mismatch("unexpected digest_word", o_digest_word, '0);
                end else begin
                    e = digest_queue.pop_front();
                    if (o_digest_word !== e.word)
                        report_mismatch("digest_word", o_digest_word, e.word);
                    if (o_digest_index !== e.index)
                        report_mismatch("digest_index", 32'(o_digest_index), 32'(e.index));
                    if (o_digest_last !== e.last)
                        report_mismatch("digest_last", 32'(o_digest_last), 32'(e.last));
                end
            end
            recv_left--;
            if (recv_left <= 0) begin
                recv_left  = $urandom_range(20, 200);
                recv_mode  = $urandom_range(0, 3);
                stall_mask = 8'($urandom);
            end
            stall_phase = stall_phase + 3'd1;
            case (recv_mode)
                0: pop_next = 1'b1;
                1: pop_next = 1'($urandom_range(0, 1));
                2: pop_next = ($urandom_range(0, 7) == 0);
                default: pop_next = stall_mask[stall_phase];
            endcase
            pop <= pop_next;
        end
    end

    initial begin
        int msg_count;
        int digests;
        int nblocks;
        logic use_first;
        logic end_last;
        logic fl;
        logic ll;

        // "abc" padded into one block, flags raised on every word so the
        // ones off word 0 and word 15 must be ignored
        for (int w = 0; w < 16; w++) begin
            add_word(w == 0 ? 32'h6162_6380 : (w == 15 ? 32'h0000_0018 : 32'h0),
                     1'b1, 1'b1, 1'b0);
        end

        msg_count = 0;
        digests = 1;
        while (pending_words.size() < 112 || digests < 4) begin
            nblocks   = $urandom_range(1, 3);
            use_first = (msg_count != 1) && ($urandom_range(0, 5) != 0);
            end_last  = (msg_count == 1) || ($urandom_range(0, 7) != 0);
            for (int b = 0; b < nblocks; b++) begin
                for (int w = 0; w < 16; w++) begin
                    if (w == 0)
                        fl = (b == 0) ? use_first : ($urandom_range(0, 7) == 0);
                    else
                        fl = 1'($urandom_range(0, 1));
                    if (w == 15)
                        ll = (b == nblocks - 1) ? end_last : ($urandom_range(0, 7) == 0);
                    else
                        ll = 1'($urandom_range(0, 1));
                    if (w == 15 && ll)
                        digests++;
                    add_word(pick_word(), fl, ll,
                             b == 0 && w == 0 && (msg_count == 0 || $urandom_range(0, 3) == 0));
                end
            end
            msg_count++;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0) @(posedge i_clk);
        while (digest_queue.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* sha256_block_compression_top.f */
rtl/core/sha_pkg.sv
rtl/core/sha_front.sv
rtl/core/sha_back.sv
rtl/core/sha256_block_compression_top.sv
bench/sha256_block_compression_top_tb.sv
